[src/htsf_pkg.sv]
// Shared types and constants of the HTML tag strip filter.
package htsf_pkg;

   localparam int MaxResults = 3;
   localparam int QueueDepth = 4;
   localparam int CountWidth = 16;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   typedef struct packed {
      logic [1:0]                  cnt;
      logic [MaxResults-1:0][7:0]  bytes;
      logic                        last;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[src/htsf_front.sv]
// Front end: accepts request bytes, tracks the tag scan and builds output bundles.
module htsf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_is_last,
   input  htsf_pkg::queue_status_type   q_status,
   output logic                         push,
   output htsf_pkg::bundle_type         push_bundle
);

   localparam logic [2:0] ModeNormal  = 3'd0;
   localparam logic [2:0] ModeLt      = 3'd1;
   localparam logic [2:0] ModeLtSlash = 3'd2;
   localparam logic [2:0] ModeInTag   = 3'd3;
   localparam logic [2:0] ModePost    = 3'd4;

   localparam logic [7:0] CharLt    = 8'h3C;
   localparam logic [7:0] CharGt    = 8'h3E;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharSpace = 8'h20;

   function automatic logic is_tag_letter(input logic [7:0] b);
      return b == 8'h61 || b == 8'h41 || b == 8'h70 || b == 8'h50 ||
             b == 8'h68 || b == 8'h48;
   endfunction

   logic [2:0]       mode_ff, mode_in;
   logic [2:0]       m;
   logic [1:0]       cnt;
   logic [3:0][7:0]  buf_bytes;
   logic             do_plain;
   logic             accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      m         = mode_ff;
      cnt       = 2'd0;
      buf_bytes = '0;
      do_plain  = 1'b0;
      unique case (mode_ff)
         ModeLt: begin
            if (is_tag_letter(req_in_byte)) begin
               m = ModeInTag;
            end else if (req_in_byte == CharSlash) begin
               m = ModeLtSlash;
            end else begin
               buf_bytes[cnt] = CharLt;
               cnt = cnt + 2'd1;
               do_plain = 1'b1;
            end
         end
         ModeLtSlash: begin
            if (is_tag_letter(req_in_byte)) begin
               m = ModeInTag;
            end else begin
               buf_bytes[cnt] = CharLt;
               cnt = cnt + 2'd1;
               buf_bytes[cnt] = CharSlash;
               cnt = cnt + 2'd1;
               do_plain = 1'b1;
            end
         end
         ModeInTag: begin
            if (req_in_byte == CharGt) begin
               m = ModePost;
            end
         end
         ModePost: begin
            if (req_in_byte > CharSpace) begin
               do_plain = 1'b1;
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase
      if (do_plain) begin
         if (req_in_byte == CharLt) begin
            m = ModeLt;
         end else begin
            m = ModeNormal;
            buf_bytes[cnt] = req_in_byte;
            cnt = cnt + 2'd1;
         end
      end
      if (req_is_last) begin
         if (m == ModeLt) begin
            buf_bytes[cnt] = CharLt;
            cnt = cnt + 2'd1;
         end else if (m == ModeLtSlash) begin
            buf_bytes[cnt] = CharLt;
            cnt = cnt + 2'd1;
            buf_bytes[cnt] = CharSlash;
            cnt = cnt + 2'd1;
         end
         m = ModeNormal;
      end
   end

   assign mode_in = accept ? m : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeNormal;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign push              = accept && (cnt != 2'd0 || req_is_last);
   assign push_bundle.cnt   = cnt;
   assign push_bundle.bytes = buf_bytes[htsf_pkg::MaxResults-1:0];
   assign push_bundle.last  = req_is_last;

endmodule

[src/htsf_queue.sv]
// Small bundle queue between the front end and the back end.
module htsf_queue #(
   parameter int DEPTH = htsf_pkg::QueueDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  htsf_pkg::bundle_type        push_bundle,
   input  logic                        pop,
   output htsf_pkg::bundle_type        head,
   output htsf_pkg::queue_status_type  status
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   htsf_pkg::bundle_type  mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = count_ff == CntFull;
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/htsf_back.sv]
// Back end: unpacks bundles into single responses and keeps the byte count.
module htsf_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  htsf_pkg::bundle_type                 head,
   input  htsf_pkg::queue_status_type           q_status,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_byte_valid,
   output logic                                 rsp_run_last,
   output logic                                 rsp_text_end,
   output logic [htsf_pkg::CountWidth-1:0]      rsp_kept_count
);

   logic                               valid_ff, valid_in;
   logic [7:0]                         byte_ff;
   logic                               bvalid_ff, run_last_ff, text_end_ff;
   logic [htsf_pkg::CountWidth-1:0]    count_ff;
   logic [htsf_pkg::CountWidth-1:0]    total_ff, total_in;
   logic [1:0]                         idx_ff, idx_in;
   logic [1:0]                         n_eff;
   logic                               load, is_end, has_byte;
   logic [htsf_pkg::CountWidth-1:0]    new_total;
   logic [7:0]                         sel_byte;

   assign load     = !q_status.empty && (!valid_ff || rsp_ready);
   assign has_byte = head.cnt != 2'd0;
   assign n_eff    = has_byte ? head.cnt : 2'd1;
   assign is_end   = idx_ff == n_eff - 2'd1;
   assign pop      = load && is_end;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.bytes[0];
         2'd1:    sel_byte = head.bytes[1];
         default: sel_byte = head.bytes[2];
      endcase
      if (!has_byte) begin
         sel_byte = 8'h00;
      end
   end

   assign new_total = (has_byte && total_ff != htsf_pkg::CountMax) ?
                      total_ff + htsf_pkg::CountWidth'(1) : total_ff;

   always_comb begin
      valid_in = valid_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         total_in = (head.last && is_end) ? '0 : new_total;
         idx_in   = is_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= sel_byte;
         bvalid_ff   <= has_byte;
         run_last_ff <= is_end;
         text_end_ff <= is_end && head.last;
         count_ff    <= new_total;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_text_end   = text_end_ff;
   assign rsp_kept_count = count_ff;

endmodule

[src/html_tag_strip_filter.sv]
// Top level of the HTML tag strip filter.
// The block strips opening tags that start with a, p or h and closing tags
// that start with /a, /p or /h, in either case, from a byte stream, along with
// any bytes at or below space that follow the closing bracket.
// The request channel takes one text byte per cycle with a flag that marks the
// last byte of a region; the response channel returns kept bytes one per cycle
// while the receiver is ready, with the running kept count, a flag on the last
// response of each request and a flag on the final response of the region.
// A region whose last byte keeps nothing ends with one marker response.
// A request causes zero to three responses; the first passes the bundle
// queue and then the response register. Requests are taken every cycle
// while the queue between the scanner and the response unpacker has room.
// Responses leave at one per cycle while the receiver is ready; a request that
// expands into three responses holds the unpacker until all three are sent.
// When the receiver stalls, the response register holds its value and the
// queue fills; once the queue is full, request ready drops.
// A synchronous reset empties the queue, returns the scanner to normal text
// and clears the kept count.
module html_tag_strip_filter #(
   parameter int QUEUE_DEPTH = htsf_pkg::QueueDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_is_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_byte_valid,
   output logic                             rsp_run_last,
   output logic                             rsp_text_end,
   output logic [htsf_pkg::CountWidth-1:0]  rsp_kept_count
);

   htsf_pkg::queue_status_type  q_status;
   htsf_pkg::bundle_type        push_bundle;
   htsf_pkg::bundle_type        head;
   logic                        push, pop;

   htsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_is_last (req_is_last),
      .q_status    (q_status),
      .push        (push),
      .push_bundle (push_bundle)
   );

   htsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .status      (q_status)
   );

   htsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_text_end   (rsp_text_end),
      .rsp_kept_count (rsp_kept_count)
   );

   a_marker_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_run_last && rsp_text_end)
      else $error("marker response is not the final response of its region");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_end |-> rsp_run_last)
      else $error("region end without end of request");

   a_kept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_kept_count != '0)
      else $error("kept byte reported with zero count");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

endmodule

[dv/tb_html_tag_strip_filter.sv]
// Self-checking testbench for the HTML tag strip filter, with a predictor and handshake stress.
`timescale 1ns / 1ps

module tb_html_tag_strip_filter;

   localparam int RequestTarget = 470;
   localparam int StallLimit = 2000;

   typedef enum logic [2:0] {
      SCAN_TEXT, SCAN_LT, SCAN_LT_SLASH, SCAN_TAG, SCAN_BLANKS
   } scan_state_type;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE
   } ready_style_type;

   typedef enum logic [2:0] {
      PIECE_TEXT, PIECE_TAG, PIECE_BROKEN, PIECE_NOISE, PIECE_BARE_LT, PIECE_BLANKS
   } piece_kind_type;

   typedef struct packed {
      logic [7:0]                      data;
      logic                            keep;
      logic                            run_end;
      logic                            region_end;
      logic [htsf_pkg::CountWidth-1:0] count;
   } strip_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_byte_valid;
   logic rsp_run_last;
   logic rsp_text_end;
   logic [htsf_pkg::CountWidth-1:0] rsp_kept_count;

   scan_state_type scan_state = SCAN_TEXT;
   logic [htsf_pkg::CountWidth-1:0] kept_total = '0;
   strip_result_type item_results[$];
   strip_result_type awaited_results[$];
   logic [7:0] region_text[$];

   int unsigned mismatch_count = 0;
   int unsigned requests_sent = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   ready_style_type ready_style = READY_ALWAYS;
   int unsigned style_left = 0;
   logic [7:0] ready_pattern = 8'hA5;

   html_tag_strip_filter uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_run_last(rsp_run_last),
      .rsp_text_end(rsp_text_end),
      .rsp_kept_count(rsp_kept_count)
   );

   always #4 clock = ~clock;

   function automatic logic is_tag_letter(input logic [7:0] b);
      return b inside {"a", "A", "p", "P", "h", "H"};
   endfunction

   function automatic void keep_byte(input logic [7:0] b);
      strip_result_type r;
      if (kept_total != htsf_pkg::CountMax) begin
         kept_total++;
      end
      r = '{data: b, keep: 1'b1, run_end: 1'b0, region_end: 1'b0, count: kept_total};
      item_results.push_back(r);
   endfunction

   function automatic void text_byte(input logic [7:0] b);
      if (b == "<") begin
         scan_state = SCAN_LT;
      end else begin
         keep_byte(b);
      end
   endfunction

   function automatic void strip_predict(input logic [7:0] b, input logic last);
      strip_result_type r;
      item_results.delete();
      case (scan_state)
         SCAN_LT: begin
            if (is_tag_letter(b)) begin
               scan_state = SCAN_TAG;
            end else if (b == "/") begin
               scan_state = SCAN_LT_SLASH;
            end else begin
               keep_byte("<");
               scan_state = SCAN_TEXT;
               text_byte(b);
            end
         end
         SCAN_LT_SLASH: begin
            if (is_tag_letter(b)) begin
               scan_state = SCAN_TAG;
            end else begin
               keep_byte("<");
               keep_byte("/");
               scan_state = SCAN_TEXT;
               text_byte(b);
            end
         end
         SCAN_TAG: begin
            if (b == ">") begin
               scan_state = SCAN_BLANKS;
            end
         end
         SCAN_BLANKS: begin
            if (b > 8'h20) begin
               scan_state = SCAN_TEXT;
               text_byte(b);
            end
         end
         default: begin
            scan_state = SCAN_TEXT;
            text_byte(b);
         end
      endcase
      if (last) begin
         if (scan_state == SCAN_LT) begin
            keep_byte("<");
         end else if (scan_state == SCAN_LT_SLASH) begin
            keep_byte("<");
            keep_byte("/");
         end
         if (item_results.size() == 0) begin
            r = '{data: 8'h00, keep: 1'b0, run_end: 1'b0, region_end: 1'b0, count: kept_total};
            item_results.push_back(r);
         end
         r = item_results.pop_back();
         r.region_end = 1'b1;
         item_results.push_back(r);
         scan_state = SCAN_TEXT;
         kept_total = '0;
      end
      if (item_results.size() > 0) begin
         r = item_results.pop_back();
         r.run_end = 1'b1;
         item_results.push_back(r);
      end
      foreach (item_results[i]) begin
         awaited_results.push_back(item_results[i]);
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch on %s: expected %0h, got %0h at %0t ns", what, want, got, $realtime);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : response_check
      strip_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            strip_predict(req_in_byte, req_is_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected response byte", 0, rsp_out_byte);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", want.data, rsp_out_byte);
               if (rsp_byte_valid !== want.keep)
                  report_mismatch("byte_valid", want.keep, rsp_byte_valid);
               if (rsp_run_last !== want.run_end)
                  report_mismatch("run_last", want.run_end, rsp_run_last);
               if (rsp_text_end !== want.region_end)
                  report_mismatch("text_end", want.region_end, rsp_text_end);
               if (rsp_kept_count !== want.count)
                  report_mismatch("kept_count", want.count, rsp_kept_count);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         style_left = $urandom_range(16, 96);
         ready_pattern = 8'($urandom_range(1, 255));
      end
      style_left--;
      case (ready_style)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         READY_PATTERN: begin
            rsp_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
         end
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_is_last <= last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_text(input string s, input logic close_region);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], close_region && (i == s.len() - 1));
      end
   endtask

   task automatic wait_drained(input int unsigned settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic test_tag_strip;
      send_text("<a>", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(" ", 1'b0);
      send_text("x</P>", 1'b1);
   endtask

   task automatic test_literal_lt;
      send_text("<h>!<<b</9", 1'b0);
   endtask

   task automatic test_pending_end;
      send_text("<", 1'b1);
      send_text("</", 1'b1);
      send_byte(8'hFF, 1'b1);
      wait_drained(2);
   endtask

   function automatic void compose_region;
      logic [7:0] tag_letters[6] = '{"a", "A", "p", "P", "h", "H"};
      int unsigned roll;
      logic [7:0] x;
      piece_kind_type kind;
      region_text.delete();
      repeat ($urandom_range(1, 8)) begin
         roll = $urandom_range(0, 9);
         kind = (roll < 3) ? PIECE_TEXT : (roll < 6) ? PIECE_TAG : (roll == 6) ? PIECE_BROKEN :
                (roll == 7) ? PIECE_NOISE : (roll == 8) ? PIECE_BARE_LT : PIECE_BLANKS;
         case (kind)
            PIECE_TEXT: begin
               repeat ($urandom_range(1, 6))
                  region_text.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            PIECE_TAG: begin
               region_text.push_back("<");
               if ($urandom_range(0, 1)) region_text.push_back("/");
               region_text.push_back(tag_letters[$urandom_range(0, 5)]);
               repeat ($urandom_range(0, 5)) begin
                  x = 8'($urandom_range(0, 255));
                  region_text.push_back((x == ">") ? "x" : x);
               end
               region_text.push_back(">");
               repeat ($urandom_range(0, 3))
                  region_text.push_back(8'($urandom_range(0, 8'h20)));
            end
            PIECE_BROKEN: begin
               region_text.push_back("<");
               if ($urandom_range(0, 1)) region_text.push_back("/");
               region_text.push_back(8'($urandom_range(0, 255)));
            end
            PIECE_NOISE: begin
               repeat ($urandom_range(1, 4))
                  region_text.push_back(8'($urandom_range(0, 255)));
            end
            PIECE_BARE_LT: begin
               region_text.push_back("<");
               if ($urandom_range(0, 1)) region_text.push_back("/");
            end
            default: begin
               repeat ($urandom_range(1, 3))
                  region_text.push_back(8'($urandom_range(0, 8'h20)));
            end
         endcase
      end
   endfunction

   task automatic test_random_regions;
      while (requests_sent < RequestTarget) begin
         compose_region();
         foreach (region_text[i]) begin
            send_byte(region_text[i], i == region_text.size() - 1);
         end
         if ($urandom_range(0, 9) == 0) begin
            wait_drained(2);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tag_strip();
      test_literal_lt();
      test_pending_end();
      test_random_regions();
      wait_drained(10);
      if (awaited_results.size() != 0) begin
         report_mismatch("missing responses", awaited_results.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[html_tag_strip_filter.f]
src/htsf_pkg.sv
src/htsf_front.sv
src/htsf_queue.sv
src/htsf_back.sv
src/html_tag_strip_filter.sv
dv/tb_html_tag_strip_filter.sv
